### rtl/core/u8d_pkg.sv
package u8d_pkg;

	// Default width of the character counter
	localparam int COUNT_BITS_DFLT = 20;

	// Fixed field widths
	localparam int CP_BITS        = 31;
	localparam int CNT_OUT_BITS   = 20;

	// Depth of the queue between the front and the back
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

	// Stream modes
	localparam logic [1:0] MODE_NORMAL   = 2'd0;
	localparam logic [1:0] MODE_STOPPED  = 2'd1;
	localparam logic [1:0] MODE_REJECTED = 2'd2;

	// Byte order marks
	localparam logic [7:0] BOM8_B0  = 8'hEF;
	localparam logic [7:0] BOM8_B1  = 8'hBB;
	localparam logic [7:0] BOM8_B2  = 8'hBF;
	localparam logic [7:0] BOM16_FE = 8'hFE;
	localparam logic [7:0] BOM16_FF = 8'hFF;

	// Lead byte patterns
	localparam logic [7:0] LEAD2_PAT = 8'hC0;
	localparam logic [7:0] LEAD3_PAT = 8'hE0;
	localparam logic [7:0] LEAD4_PAT = 8'hF0;
	localparam logic [7:0] LEAD5_PAT = 8'hF8;
	localparam logic [7:0] LEAD6_PAT = 8'hFC;
	localparam logic [7:0] LEAD6_MSK = 8'hFE;
	localparam logic [7:0] LEAD_MASK = 8'h7F;
	localparam logic [7:0] CONT_MASK = 8'h3F;
	localparam logic [7:0] ASCII_LIM = 8'h80;

	// Replacement character '?'
	localparam logic [CP_BITS-1:0] QMARK = 31'd63;

	// One queued byte with its class
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [2:0] lead;
	} u8d_entry_t;

	// Sequence length of a byte in lead position: 1 for ascii, 2 to 6, 0 invalid
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] n;
		begin
			if (b < ASCII_LIM)                          n = 3'd1;
			else if ((b & LEAD3_PAT) == LEAD2_PAT)      n = 3'd2;
			else if ((b & LEAD4_PAT) == LEAD3_PAT)      n = 3'd3;
			else if ((b & LEAD5_PAT) == LEAD4_PAT)      n = 3'd4;
			else if ((b & LEAD6_PAT) == LEAD5_PAT)      n = 3'd5;
			else if ((b & LEAD6_MSK) == LEAD6_PAT)      n = 3'd6;
			else                                        n = 3'd0;
			return n;
		end
	endfunction

endpackage

### rtl/core/u8d_front.sv
module u8d_front import u8d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] byte_value,
	input  logic       last_byte,
	output logic       q_valid,
	output u8d_entry_t q_entry,
	input  logic       q_pop
);

	u8d_entry_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]      wr_q;
	logic [QPTR_BITS-1:0]      rd_q;
	logic [QCNT_BITS-1:0]      cnt_q;
	logic                      push;
	logic                      pop;
	u8d_entry_t                new_entry;

	assign item_ready = (cnt_q != QCNT_BITS'(QUEUE_DEPTH));
	assign q_valid    = (cnt_q != '0);
	assign push       = item_valid && item_ready;
	assign pop        = q_pop && q_valid;
	assign q_entry    = mem_q[rd_q];

	// Classify the incoming byte
	always_comb begin
		new_entry.data = byte_value;
		new_entry.last = last_byte;
		new_entry.lead = lead_len(byte_value);
	end

	// Store each transfer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= new_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/u8d_back.sv
module u8d_back import u8d_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DFLT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  u8d_entry_t              q_entry,
	output logic                    q_pop,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [CP_BITS-1:0]      code_point,
	output logic                    has_char,
	output logic                    end_of_string,
	output logic                    ascii_only,
	output logic [CNT_OUT_BITS-1:0] char_count
);

	// Decoder state
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	logic                  asc_q, asc_d;
	logic [1:0]            mode_q, mode_d;
	logic [2:0]            hc_q, hc_d;
	logic [2:0]            nt_q, nt_d;
	logic [CP_BITS-1:0]    acc_q, acc_d;
	logic [1:0]            pos_q, pos_d;
	logic [3:0][7:0]       hb_q, hb_d;
	logic [3:0][7:0]       rep_q, rep_d;
	logic [2:0]            rc_q, rc_d;
	logic                  rep_end_q, rep_end_d;
	logic                  endp_q, endp_d;

	// Result register
	logic                  ov_q;
	logic [CP_BITS-1:0]    cp_q;
	logic                  has_q;
	logic                  end_q;
	logic                  asc_out_q;
	logic [COUNT_BITS-1:0] cnt_out_q;

	logic                  adv;
	logic                  use_feed;
	logic [7:0]            fb;
	logic [2:0]            fl;
	logic [2:0]            hc_inc;
	logic [CP_BITS-1:0]    acc_sh;
	logic                  e_valid;
	logic [CP_BITS-1:0]    e_cp;
	logic                  e_has;
	logic                  e_end;
	logic                  e_asc;
	logic [COUNT_BITS-1:0] e_cnt;
	logic                  is_bom8;
	logic                  is_bom16;

	assign adv = !ov_q || result_ready;

	// Feed byte: replay buffer first, then the queue
	assign fb     = (rc_q != 3'd0) ? rep_q[0] : q_entry.data;
	assign fl     = (rc_q != 3'd0) ? lead_len(rep_q[0]) : q_entry.lead;
	assign hc_inc = hc_q + 3'd1;
	assign acc_sh = {acc_q[CP_BITS-7:0], fb[5:0] & CONT_MASK[5:0]};

	assign is_bom8  = (rep_q[0] == BOM8_B0) && (rep_q[1] == BOM8_B1)
		&& (q_entry.data == BOM8_B2);
	assign is_bom16 = ((rep_q[0] == BOM16_FE) && (rep_q[1] == BOM16_FF))
		|| ((rep_q[0] == BOM16_FF) && (rep_q[1] == BOM16_FE));

	// Step the decoder: at most one result per cycle
	always_comb begin
		cnt_d     = cnt_q;
		asc_d     = asc_q;
		mode_d    = mode_q;
		hc_d      = hc_q;
		nt_d      = nt_q;
		acc_d     = acc_q;
		pos_d     = pos_q;
		hb_d      = hb_q;
		rep_d     = rep_q;
		rc_d      = rc_q;
		rep_end_d = rep_end_q;
		endp_d    = endp_q;
		use_feed  = 1'b0;
		q_pop     = 1'b0;
		e_valid   = 1'b0;
		e_cp      = '0;
		e_has     = 1'b0;
		e_end     = 1'b0;

		if (adv) begin
			if (endp_q) begin
				if (hc_q != 3'd0 && mode_q == MODE_NORMAL) begin
					// cut-short sequence: '?' and replay the bytes after its lead
					e_valid   = 1'b1;
					e_has     = 1'b1;
					e_cp      = QMARK;
					rep_d     = hb_q;
					rc_d      = hc_q - 3'd1;
					rep_end_d = 1'b1;
					endp_d    = (hc_q == 3'd1);
					hc_d      = '0;
					nt_d      = '0;
					acc_d     = '0;
				end else begin
					// end result, then clear per-string state
					e_valid = 1'b1;
					e_end   = 1'b1;
					endp_d  = 1'b0;
					hc_d    = '0;
					nt_d    = '0;
					acc_d   = '0;
					pos_d   = '0;
					mode_d  = MODE_NORMAL;
					asc_d   = 1'b1;
					cnt_d   = '0;
				end
			end else if (rc_q != 3'd0) begin
				// replay one held byte
				use_feed = 1'b1;
				rep_d    = {8'h00, rep_q[3:1]};
				rc_d     = rc_q - 3'd1;
				if (rc_q == 3'd1 && rep_end_q) begin
					endp_d = 1'b1;
				end
			end else if (q_valid) begin
				q_pop = 1'b1;
				if (pos_q != 2'd3) begin
					// hold the opening bytes until the mark check
					rep_d[pos_q] = q_entry.data;
					pos_d        = pos_q + 2'd1;
					if (pos_q == 2'd2) begin
						if (is_bom8) begin
							endp_d = q_entry.last;
						end else if (is_bom16) begin
							mode_d = MODE_REJECTED;
							endp_d = q_entry.last;
						end else begin
							rc_d      = 3'd3;
							rep_end_d = q_entry.last;
						end
					end else if (q_entry.last) begin
						rc_d      = {1'b0, pos_q} + 3'd1;
						rep_end_d = 1'b1;
					end
				end else begin
					use_feed = 1'b1;
					endp_d   = q_entry.last;
				end
			end
		end

		// Feed one byte through the sequence decoder
		if (use_feed && mode_q == MODE_NORMAL) begin
			if (hc_q == 3'd0) begin
				if (fb == 8'h00) begin
					mode_d = MODE_STOPPED;
				end else if (fl == 3'd1) begin
					e_valid = 1'b1;
					e_has   = 1'b1;
					e_cp    = CP_BITS'(fb);
				end else begin
					asc_d = 1'b0;
					if (fl == 3'd0) begin
						e_valid = 1'b1;
						e_has   = 1'b1;
						e_cp    = QMARK;
					end else begin
						hc_d  = 3'd1;
						nt_d  = fl;
						acc_d = CP_BITS'(fb & (LEAD_MASK >> fl));
					end
				end
			end else begin
				if (hc_q <= 3'd4) begin
					hb_d[2'(hc_q - 3'd1)] = fb;
				end
				if (hc_inc >= nt_q) begin
					e_valid = 1'b1;
					e_has   = 1'b1;
					e_cp    = acc_sh;
					hc_d    = '0;
					nt_d    = '0;
					acc_d   = '0;
				end else begin
					hc_d  = hc_inc;
					acc_d = acc_sh;
				end
			end
		end

		// Count characters, saturating
		if (e_has && cnt_q != '1) begin
			cnt_d = cnt_q + 1'b1;
		end

		e_asc = e_end ? asc_q : asc_d;
		e_cnt = e_end ? cnt_q : cnt_d;
	end

	// Hold byte buffers
	always_ff @(posedge clk) begin
		hb_q  <= hb_d;
		rep_q <= rep_d;
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (adv && e_valid) begin
			cp_q      <= e_cp;
			has_q     <= e_has;
			end_q     <= e_end;
			asc_out_q <= e_asc;
			cnt_out_q <= e_cnt;
		end
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			asc_q     <= 1'b1;
			mode_q    <= MODE_NORMAL;
			hc_q      <= '0;
			nt_q      <= '0;
			acc_q     <= '0;
			pos_q     <= '0;
			rc_q      <= '0;
			rep_end_q <= 1'b0;
			endp_q    <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			cnt_q     <= cnt_d;
			asc_q     <= asc_d;
			mode_q    <= mode_d;
			hc_q      <= hc_d;
			nt_q      <= nt_d;
			acc_q     <= acc_d;
			pos_q     <= pos_d;
			rc_q      <= rc_d;
			rep_end_q <= rep_end_d;
			endp_q    <= endp_d;
			if (adv) begin
				ov_q <= e_valid;
			end
		end
	end

	assign result_valid  = ov_q;
	assign code_point    = cp_q;
	assign has_char      = has_q;
	assign end_of_string = end_q;
	assign ascii_only    = asc_out_q;
	assign char_count    = CNT_OUT_BITS'(cnt_out_q);

endmodule

### rtl/core/utf8_to_code_point_decoder_unit.sv
// UTF-8 decoder with the legacy lead bytes of up to six bytes (code points up to
// 31 bits). One byte is taken per transfer on the item channel; last_byte closes a
// string. Each decoded character leaves as one transfer on the result channel, and
// every string ends with one extra result that has end_of_string set and carries the
// ascii_only flag and the saturating character count. Plain text streams at one byte
// per clock while result_ready stays high. The decode engine handles one byte or one
// result per cycle when it is not stalled, which sets the cost of bursts. The third
// byte of a string that does not open with a byte order mark is taken, and then each
// of the three held opening bytes is decoded in turn. A last byte also yields the end
// result. When a sequence is cut short at the end, the engine emits a '?' and replays
// each byte held after its lead, and repeats that while the replayed bytes leave
// another sequence pending. A four-entry queue separates byte acceptance from the
// engine, which stalls while a result waits in the result register; the queue keeps
// taking bytes until it is full.
module utf8_to_code_point_decoder_unit import u8d_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DFLT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [7:0]              byte_value,
	input  logic                    last_byte,
	output logic                    result_valid,
	input  logic                    result_ready,
	output logic [CP_BITS-1:0]      code_point,
	output logic                    has_char,
	output logic                    end_of_string,
	output logic                    ascii_only,
	output logic [CNT_OUT_BITS-1:0] char_count
);

	logic       q_valid;
	u8d_entry_t q_entry;
	logic       q_pop;

	// Accept and classify bytes
	u8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop)
	);

	// Decode and deliver results
	u8d_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_entry       (q_entry),
		.q_pop         (q_pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.code_point    (code_point),
		.has_char      (has_char),
		.end_of_string (end_of_string),
		.ascii_only    (ascii_only),
		.char_count    (char_count)
	);

endmodule

### bench/utf8_decode_checker.sv
`timescale 1ns / 100ps

module utf8_decode_checker import u8d_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  logic                    item_ready,
	input  logic [7:0]              byte_value,
	input  logic                    last_byte,
	input  logic                    result_valid,
	input  logic                    result_ready,
	input  logic [CP_BITS-1:0]      code_point,
	input  logic                    has_char,
	input  logic                    end_of_string,
	input  logic                    ascii_only,
	input  logic [CNT_OUT_BITS-1:0] char_count,
	output int                      fail_count,
	output int                      backlog
);

	localparam int COUNT_BITS = COUNT_BITS_DFLT;
	localparam longint unsigned CHAR_CAP = (64'd1 << COUNT_BITS) - 64'd1;
	localparam int MAX_PER_BYTE = 6;

	typedef struct packed {
		logic [CP_BITS-1:0]      cp;
		logic                    has;
		logic                    eos;
		logic                    ascii;
		logic [CNT_OUT_BITS-1:0] cnt;
	} decoded_t;

	// Results still owed by the block, oldest first
	decoded_t decoded_q[$];

	// Decoder state mirrored from the block's behavior
	logic [7:0]         seq_buf [5];
	int unsigned        seq_held = 0;
	int unsigned        seq_need = 0;
	logic [CP_BITS-1:0] cp_acc = '0;
	int unsigned        opening_seen = 0;
	logic [1:0]         mode = MODE_NORMAL;
	logic               pure_ascii = 1'b1;
	longint unsigned    char_total = 0;
	int unsigned        step_results = 0;
	int                 mismatches = 0;

	// Sequence length for a byte of 0x80 or above; 0 when it cannot lead
	function automatic int unsigned seq_length(input logic [7:0] b);
		if (b[7:5] == 3'b110)
			return 2;
		if (b[7:4] == 4'b1110)
			return 3;
		if (b[7:3] == 5'b11110)
			return 4;
		if (b[7:2] == 6'b111110)
			return 5;
		if (b[7:1] == 7'b1111110)
			return 6;
		return 0;
	endfunction

	task automatic emit(input logic [CP_BITS-1:0] cp, input logic has, input logic eos);
		decoded_t r;
		if (step_results < MAX_PER_BYTE) begin
			r.cp    = cp;
			r.has   = has;
			r.eos   = eos;
			r.ascii = pure_ascii;
			r.cnt   = char_total[CNT_OUT_BITS-1:0];
			decoded_q.insert(decoded_q.size(), r);
			step_results++;
		end
	endtask

	// Count the character, saturating, then queue it
	task automatic emit_char(input logic [CP_BITS-1:0] cp);
		if (char_total < CHAR_CAP)
			char_total++;
		emit(cp, 1'b1, 1'b0);
	endtask

	// Take one byte in normal decoding
	task automatic absorb(input logic [7:0] b);
		int unsigned n;
		if (mode != MODE_NORMAL)
			return;
		if (seq_held == 0) begin
			if (b == 8'h00) begin
				mode = MODE_STOPPED;
				return;
			end
			if (b < ASCII_LIM) begin
				emit_char(CP_BITS'(b));
				return;
			end
			pure_ascii = 1'b0;
			n = seq_length(b);
			if (n == 0) begin
				emit_char(QMARK);
				return;
			end
			seq_buf[0] = b;
			seq_held   = 1;
			seq_need   = n;
			cp_acc     = CP_BITS'(b & (8'h7F >> n));
			return;
		end
		cp_acc = {cp_acc[CP_BITS-7:0], b[5:0]};
		if (seq_held < 5)
			seq_buf[seq_held] = b;
		seq_held++;
		if (seq_held >= seq_need) begin
			emit_char(cp_acc);
			seq_held = 0;
			seq_need = 0;
			cp_acc   = '0;
		end
	endtask

	// Replace a cut-short sequence with '?' and decode what followed its lead
	task automatic resolve_cut();
		logic [7:0]         tmp [5];
		int unsigned        len, i, n, k;
		logic [CP_BITS-1:0] acc;
		tmp      = seq_buf;
		len      = (seq_held > 5) ? 5 : seq_held;
		seq_held = 0;
		seq_need = 0;
		cp_acc   = '0;
		i        = 0;
		while (i < len && mode == MODE_NORMAL) begin
			if (tmp[i] == 8'h00) begin
				mode = MODE_STOPPED;
			end else if (tmp[i] < ASCII_LIM) begin
				emit_char(CP_BITS'(tmp[i]));
				i++;
			end else begin
				pure_ascii = 1'b0;
				n = seq_length(tmp[i]);
				if (n != 0 && i + n <= len) begin
					acc = CP_BITS'(tmp[i] & (8'h7F >> n));
					for (k = 1; k < n; k++)
						acc = {acc[CP_BITS-7:0], tmp[i+k][5:0]};
					emit_char(acc);
					i += n;
				end else begin
					emit_char(QMARK);
					i++;
				end
			end
		end
	endtask

	// Decode the held opening bytes
	task automatic replay_opening(input int unsigned len);
		logic [7:0]  first [3];
		int unsigned i;
		for (i = 0; i < 3; i++)
			first[i] = seq_buf[i];
		seq_held = 0;
		for (i = 0; i < len; i++)
			absorb(first[i]);
	endtask

	task automatic clear_string();
		seq_held     = 0;
		seq_need     = 0;
		cp_acc       = '0;
		opening_seen = 0;
		mode         = MODE_NORMAL;
		pure_ascii   = 1'b1;
		char_total   = 0;
	endtask

	// Work out every result that one accepted byte causes
	task automatic predict_byte(input logic [7:0] b, input logic last);
		step_results = 0;
		if (opening_seen < 3) begin
			seq_buf[opening_seen] = b;
			opening_seen++;
			seq_held = opening_seen;
			if (opening_seen == 3) begin
				if (seq_buf[0] == BOM8_B0 && seq_buf[1] == BOM8_B1 && seq_buf[2] == BOM8_B2) begin
					seq_held = 0;
				end else if ((seq_buf[0] == BOM16_FE && seq_buf[1] == BOM16_FF) ||
						(seq_buf[0] == BOM16_FF && seq_buf[1] == BOM16_FE)) begin
					seq_held = 0;
					mode     = MODE_REJECTED;
				end else begin
					replay_opening(3);
				end
			end else if (last) begin
				replay_opening(opening_seen);
			end
		end else begin
			absorb(b);
		end
		if (last) begin
			if (seq_held != 0 && mode == MODE_NORMAL)
				resolve_cut();
			emit('0, 1'b0, 1'b1);
			clear_string();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Compare each result transfer, then predict from each byte transfer
	always @(posedge clk) begin : watch
		decoded_t want;
		if (!arst_n) begin
			clear_string();
			decoded_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (decoded_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, code_point %0h end_of_string %0b",
						$time, code_point, end_of_string);
				end else begin
					want = decoded_q.pop_front();
					check_field("code_point", 32'(want.cp), 32'(code_point));
					check_field("has_char", 32'(want.has), 32'(has_char));
					check_field("end_of_string", 32'(want.eos), 32'(end_of_string));
					check_field("ascii_only", 32'(want.ascii), 32'(ascii_only));
					check_field("char_count", 32'(want.cnt), 32'(char_count));
				end
			end
			if (item_valid && item_ready)
				predict_byte(byte_value, last_byte);
		end
		fail_count <= mismatches;
		backlog    <= decoded_q.size();
	end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb import u8d_pkg::*; ();

	localparam int RANDOM_ITEMS = 350;
	localparam int HOLD_FROM    = 150;
	localparam int HOLD_LEN     = 100;
	localparam int SINK_CALM_LO = 700;
	localparam int SINK_CALM_HI = 900;
	localparam int DRAIN_CYCLES = 20;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    item_valid = 1'b0;
	logic                    item_ready;
	logic [7:0]              byte_value = '0;
	logic                    last_byte = 1'b0;
	logic                    result_valid;
	logic                    result_ready = 1'b0;
	logic [CP_BITS-1:0]      code_point;
	logic                    has_char;
	logic                    end_of_string;
	logic                    ascii_only;
	logic [CNT_OUT_BITS-1:0] char_count;

	int          fail_count;
	int          backlog;
	int          sent = 0;
	logic        steady = 1'b0;
	int unsigned sink_cycle = 0;
	logic [7:0]  text_q[$];

	utf8_to_code_point_decoder_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.byte_value    (byte_value),
		.last_byte     (last_byte),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.code_point    (code_point),
		.has_char      (has_char),
		.end_of_string (end_of_string),
		.ascii_only    (ascii_only),
		.char_count    (char_count)
	);

	utf8_decode_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.byte_value    (byte_value),
		.last_byte     (last_byte),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.code_point    (code_point),
		.has_char      (has_char),
		.end_of_string (end_of_string),
		.ascii_only    (ascii_only),
		.char_count    (char_count),
		.fail_count    (fail_count),
		.backlog       (backlog)
	);

	always #1 clk = ~clk;

	// Drain results: one long hold-off, one calm stretch, random stalls elsewhere
	always @(posedge clk) begin
		if (arst_n)
			sink_cycle <= sink_cycle + 1;
		if (arst_n && sink_cycle >= HOLD_FROM && sink_cycle < HOLD_FROM + HOLD_LEN)
			result_ready <= 1'b0;
		else if (sink_cycle >= SINK_CALM_LO && sink_cycle < SINK_CALM_HI)
			result_ready <= 1'b1;
		else
			result_ready <= ($urandom_range(99) >= 38);
	end

	// Offer one byte, idling at random first, and hold it until the transfer
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!steady && $urandom_range(99) < 38) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		byte_value <= b;
		last_byte  <= last;
		do
			@(posedge clk);
		while (!item_ready);
	endtask

	task automatic send_string();
		int k;
		for (k = 0; k < text_q.size(); k++) begin
			send_byte(text_q[k], k == text_q.size() - 1);
			sent++;
		end
		text_q.delete();
	endtask

	// Append one byte to the string being built
	task automatic put_text(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endtask

	// Append a well-formed multi-byte sequence; continuations are sometimes junk
	task automatic add_seq(input int unsigned n);
		logic [7:0]  lead;
		int unsigned k;
		case (n)
			2: begin
				lead = {3'b110, 5'($urandom)};
			end
			3: begin
				lead = {4'b1110, 4'($urandom)};
			end
			4: begin
				lead = {5'b11110, 3'($urandom)};
			end
			5: begin
				lead = {6'b111110, 2'($urandom)};
			end
			default: begin
				lead = {7'b1111110, 1'($urandom)};
			end
		endcase
		put_text(lead);
		for (k = 1; k < n; k++)
			put_text(($urandom_range(7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)});
	endtask

	// Build one random string: mostly well-formed text, some marks, noise and cut ends
	task automatic make_string();
		int unsigned kind, len, k, r, drop;
		kind = $urandom_range(99);
		if (kind < 10) begin
			len = $urandom_range(1, 8);
			for (k = 0; k < len; k++)
				put_text(8'($urandom));
			return;
		end
		r = $urandom_range(99);
		if (r < 8) begin
			put_text(BOM8_B0);
			put_text(BOM8_B1);
			put_text(BOM8_B2);
		end else if (r < 13) begin
			if ($urandom_range(1) == 0) begin
				put_text(BOM16_FE);
				put_text(BOM16_FF);
			end else begin
				put_text(BOM16_FF);
				put_text(BOM16_FE);
			end
		end
		len = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
		for (k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (r < 50)
				put_text(($urandom_range(39) == 0) ? 8'h00 : 8'($urandom_range(1, 127)));
			else if (r < 92)
				add_seq($urandom_range(2, 6));
			else if ($urandom_range(3) == 0)
				put_text({7'b1111111, 1'($urandom)});
			else
				put_text(8'($urandom_range(8'h80, 8'hBF)));
		end
		// Cut the tail so the last sequence often ends short
		if ($urandom_range(99) < 20) begin
			drop = $urandom_range(1, 3);
			while (drop != 0 && text_q.size() > 1) begin
				void'(text_q.pop_back());
				drop--;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single ascii byte
		text_q = '{8'h41};
		send_string();
		// Zero lead stops the rest of a short string
		text_q = '{8'h00, 8'h7F};
		send_string();
		// Two-byte string gets no mark check: two invalid leads
		text_q = '{BOM16_FF, BOM16_FE};
		send_string();
		// UTF-8 mark skipped
		text_q = '{BOM8_B0, BOM8_B1, BOM8_B2, 8'h41};
		send_string();
		// UTF-16 mark rejects the whole string
		text_q = '{BOM16_FE, BOM16_FF, 8'h41};
		send_string();
		// Largest six-byte code point
		text_q = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
		send_string();
		// Six-byte lead cut short after five bytes: the most results per byte
		text_q = '{8'hFC, 8'h41, 8'h42, 8'h43, 8'h44};
		send_string();
		// Zero after a lead is data
		text_q = '{8'hC3, 8'h00};
		send_string();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (sent >= 180 && sent < 250);
			make_string();
			send_string();
		end
		item_valid <= 1'b0;

		// Wait for every owed result, then let the block settle
		@(posedge clk);
		while (backlog != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
